[hdl/gsa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generational slot allocator package
// Table sizes, field widths and the operation and status codes that the
// allocator and its testbench share.
// ----------------------------------------------------------------------------
package gsa_pkg;

   localparam int SLOT_COUNT      = 256;
   localparam int GENERATION_BITS = 16;

   localparam int IDX_W = $clog2(SLOT_COUNT);
   localparam int CNT_W = $clog2(SLOT_COUNT + 1);

   localparam int OP_W       = 1;
   localparam int SIZE_W     = 32;
   localparam int HINDEX_W   = 8;
   localparam int HGEN_W     = 16;
   localparam int STATUS_W   = 2;
   localparam int SLOT_IDX_W = 8;
   localparam int SLOT_GEN_W = 16;

   typedef logic [OP_W-1:0]            op_type;
   typedef logic [STATUS_W-1:0]        status_type;
   typedef logic [IDX_W-1:0]           index_type;
   typedef logic [CNT_W-1:0]           count_type;
   typedef logic [GENERATION_BITS-1:0] gen_type;

   localparam op_type OP_ALLOC   = 1'b0;
   localparam op_type OP_RELEASE = 1'b1;

   localparam status_type STATUS_OK      = 2'd0;
   localparam status_type STATUS_BAD_SIZE = 2'd1;
   localparam status_type STATUS_FULL    = 2'd2;
   localparam status_type STATUS_IGNORED = 2'd3;

endpackage

[hdl/gsa_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/generational_slot_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generational slot allocator
// Hands out index and generation handles from a fixed slot table and
// validates their release.
// ----------------------------------------------------------------------------
// Usage:
// Requests enter on the req_ channel and each produces exactly one result on
// the rsp_ channel, both with valid and ready handshakes. An allocate with a
// zero size, a full table, a release of a never-used index and an allocate of
// a fresh slot finish in the cycle of the transfer; the result is registered
// and visible in the cycle after. A release reads the slot's generation memory
// and answers from the CHECK state. An allocate that reuses a freed slot reads
// the free stack and then the generation memory, through the POP and BUMP
// states, and answers from BUMP. One request is in work at a time. The result
// register is separate from the request side: a new request is taken while a
// result is being transferred. When the receiver stalls, the result holds and
// no new request is taken. Reset clears the counters and the control state
// only; the memories need no clearing, since an entry is read only after it
// has been written.
// ----------------------------------------------------------------------------
module generational_slot_allocator (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [gsa_pkg::OP_W-1:0]       req_op,
   input  logic [gsa_pkg::SIZE_W-1:0]     req_size_bytes,
   input  logic [gsa_pkg::HINDEX_W-1:0]   req_handle_index,
   input  logic [gsa_pkg::HGEN_W-1:0]     req_handle_generation,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [gsa_pkg::STATUS_W-1:0]   rsp_status,
   output logic [gsa_pkg::SLOT_IDX_W-1:0] rsp_slot_index,
   output logic [gsa_pkg::SLOT_GEN_W-1:0] rsp_slot_generation
);

   import gsa_pkg::*;

   localparam int ST_W = 2;
   localparam logic [ST_W-1:0] ST_IDLE  = 2'd0;
   localparam logic [ST_W-1:0] ST_POP   = 2'd1;
   localparam logic [ST_W-1:0] ST_BUMP  = 2'd2;
   localparam logic [ST_W-1:0] ST_CHECK = 2'd3;

   localparam int GE_W = GENERATION_BITS + 1;

   logic [ST_W-1:0] state_ff, state_in;
   count_type       free_cnt_ff, free_cnt_in;
   count_type       used_ff, used_in;
   index_type       idx_ff, idx_in;
   logic [HGEN_W-1:0] hgen_ff, hgen_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [SLOT_IDX_W-1:0] rsp_index_ff, rsp_index_in;
   logic [SLOT_GEN_W-1:0] rsp_gen_ff, rsp_gen_in;

   logic            gen_we, gen_re;
   index_type       gen_waddr, gen_raddr;
   logic [GE_W-1:0] gen_wdata, gen_rdata;
   logic            stk_we, stk_re;
   index_type       stk_waddr, stk_raddr;
   index_type       stk_wdata, stk_rdata;

   logic    accept, produce;
   gen_type stored_gen, bumped_gen;
   logic    stored_live;

   assign accept      = req_valid && req_ready;
   assign req_ready   = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign stored_live = gen_rdata[GE_W-1];
   assign stored_gen  = gen_rdata[GENERATION_BITS-1:0];
   assign bumped_gen  = stored_gen + GENERATION_BITS'(1);

   always_comb begin
      state_in      = state_ff;
      free_cnt_in   = free_cnt_ff;
      used_in       = used_ff;
      idx_in        = idx_ff;
      hgen_in       = hgen_ff;
      produce       = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_gen_in    = rsp_gen_ff;
      gen_we        = 1'b0;
      gen_waddr     = idx_ff;
      gen_wdata     = {1'b1, GENERATION_BITS'(1)};
      gen_re        = 1'b0;
      gen_raddr     = IDX_W'(req_handle_index);
      stk_we        = 1'b0;
      stk_waddr     = free_cnt_ff[IDX_W-1:0];
      stk_wdata     = idx_ff;
      stk_re        = 1'b0;
      stk_raddr     = free_cnt_ff[IDX_W-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_index_in = '0;
               rsp_gen_in   = '0;
               if (req_op == OP_ALLOC) begin
                  priority if (req_size_bytes == '0) begin
                     produce       = 1'b1;
                     rsp_status_in = STATUS_BAD_SIZE;
                  end else if (free_cnt_ff != '0) begin
                     free_cnt_in = free_cnt_ff - CNT_W'(1);
                     stk_re      = 1'b1;
                     stk_raddr   = free_cnt_in[IDX_W-1:0];
                     state_in    = ST_POP;
                  end else if (32'(used_ff) < SLOT_COUNT) begin
                     gen_we        = 1'b1;
                     gen_waddr     = used_ff[IDX_W-1:0];
                     used_in       = used_ff + CNT_W'(1);
                     produce       = 1'b1;
                     rsp_status_in = STATUS_OK;
                     rsp_index_in  = SLOT_IDX_W'(used_ff[IDX_W-1:0]);
                     rsp_gen_in    = SLOT_GEN_W'(GENERATION_BITS'(1));
                  end else begin
                     produce       = 1'b1;
                     rsp_status_in = STATUS_FULL;
                  end
               end else begin
                  if (32'(req_handle_index) >= 32'(used_ff)) begin
                     produce       = 1'b1;
                     rsp_status_in = STATUS_IGNORED;
                  end else begin
                     gen_re   = 1'b1;
                     idx_in   = IDX_W'(req_handle_index);
                     hgen_in  = req_handle_generation;
                     state_in = ST_CHECK;
                  end
               end
            end
         end
         ST_POP: begin
            gen_re    = 1'b1;
            gen_raddr = stk_rdata;
            idx_in    = stk_rdata;
            state_in  = ST_BUMP;
         end
         ST_BUMP: begin
            gen_we        = 1'b1;
            gen_wdata     = {1'b1, bumped_gen};
            produce       = 1'b1;
            rsp_status_in = STATUS_OK;
            rsp_index_in  = SLOT_IDX_W'(idx_ff);
            rsp_gen_in    = SLOT_GEN_W'(bumped_gen);
            state_in      = ST_IDLE;
         end
         ST_CHECK: begin
            produce  = 1'b1;
            state_in = ST_IDLE;
            if (stored_live && (HGEN_W'(stored_gen) == hgen_ff)) begin
               gen_we        = 1'b1;
               gen_wdata     = {1'b0, stored_gen};
               rsp_status_in = STATUS_OK;
               if (32'(free_cnt_ff) < SLOT_COUNT) begin
                  stk_we      = 1'b1;
                  free_cnt_in = free_cnt_ff + CNT_W'(1);
               end
            end else begin
               rsp_status_in = STATUS_IGNORED;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = produce || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         free_cnt_ff  <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         free_cnt_ff  <= free_cnt_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      hgen_ff       <= hgen_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_gen_ff    <= rsp_gen_in;
   end

   gsa_ram #(
      .WIDTH (GE_W),
      .DEPTH (SLOT_COUNT)
   ) u_gen_ram (
      .clock   (clock),
      .wr_en   (gen_we),
      .wr_addr (gen_waddr),
      .wr_data (gen_wdata),
      .rd_en   (gen_re),
      .rd_addr (gen_raddr),
      .rd_data (gen_rdata)
   );

   gsa_ram #(
      .WIDTH (IDX_W),
      .DEPTH (SLOT_COUNT)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (stk_wdata),
      .rd_en   (stk_re),
      .rd_addr (stk_raddr),
      .rd_data (stk_rdata)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_slot_index      = rsp_index_ff;
   assign rsp_slot_generation = rsp_gen_ff;

`ifndef NO_ASSERTIONS
   a_free_within_used : assert property (@(posedge clock) disable iff (reset)
      free_cnt_ff <= used_ff)
      else $error("free stack holds more entries than slots ever used");

   a_used_bounded : assert property (@(posedge clock) disable iff (reset)
      32'(used_ff) <= SLOT_COUNT)
      else $error("slot high-water mark exceeds the table size");

   a_busy_no_result : assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !rsp_valid_ff)
      else $error("result pending while a request is still in work");

   a_fail_zero_payload : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != STATUS_OK))
         |-> (rsp_index_ff == '0) && (rsp_gen_ff == '0))
      else $error("failed request carries a nonzero handle");

   a_single_write_port : assert property (@(posedge clock) disable iff (reset)
      stk_we |-> (state_ff == ST_CHECK) && gen_we)
      else $error("free stack push outside a valid release");
`endif

endmodule

[tb/tb_generational_slot_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generational slot allocator testbench
// Drives allocate and release requests through the request channel while
// both sides idle at random. A local copy of the slot table, live bits and
// free stack predicts each result, and every result transfer is compared
// with the oldest prediction. The run covers directed corner cases, random
// traffic, a full table and repeated reuse of one slot.
// ----------------------------------------------------------------------------
module tb_generational_slot_allocator;
   import gsa_pkg::*;

   localparam int CYCLE_LIMIT = 5000000;

   typedef struct packed {
      status_type            status;
      logic [SLOT_IDX_W-1:0] index;
      logic [SLOT_GEN_W-1:0] gen;
   } answer_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [OP_W-1:0]       req_op = OP_ALLOC;
   logic [SIZE_W-1:0]     req_size_bytes = '0;
   logic [HINDEX_W-1:0]   req_handle_index = '0;
   logic [HGEN_W-1:0]     req_handle_generation = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [STATUS_W-1:0]   rsp_status;
   logic [SLOT_IDX_W-1:0] rsp_slot_index;
   logic [SLOT_GEN_W-1:0] rsp_slot_generation;

   gen_type   slot_gen [SLOT_COUNT];
   bit        slot_live [SLOT_COUNT];
   index_type freed_stack [SLOT_COUNT];
   count_type freed_depth = '0;
   count_type high_water = '0;

   answer_type awaited_answers [$];
   int      status_seen [4] = '{0, 0, 0, 0};
   int      wrap_count = 0;
   int      errors = 0;
   int      cycle_count = 0;
   int      stall_left = 0;
   bit      pacing = 1'b1;

   generational_slot_allocator dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_op                (req_op),
      .req_size_bytes        (req_size_bytes),
      .req_handle_index      (req_handle_index),
      .req_handle_generation (req_handle_generation),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_status            (rsp_status),
      .rsp_slot_index        (rsp_slot_index),
      .rsp_slot_generation   (rsp_slot_generation)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int idle_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (!pacing || roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Searches from a random start for a handed-out slot in the wanted live state.
   function automatic bit find_slot(input bit live_wanted, output index_type idx);
      int start;
      int j;
      start = $urandom_range(0, SLOT_COUNT - 1);
      idx = '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         j = (start + i) % SLOT_COUNT;
         if (j < high_water && slot_live[j] == live_wanted) begin
            idx = index_type'(j);
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic logic [SIZE_W-1:0] random_size();
      int roll;
      roll = $urandom_range(0, 19);
      if (roll == 0) return '0;
      if (roll == 1) return 32'd1;
      if (roll == 2) return 32'hFFFF_FFFF;
      return $urandom;
   endfunction

   task automatic resolve_request(input op_type op, input logic [SIZE_W-1:0] size,
                                  input logic [HINDEX_W-1:0] hidx,
                                  input logic [HGEN_W-1:0] hgen);
      answer_type ans;
      index_type  idx;
      ans = '{status: STATUS_OK, index: '0, gen: '0};
      if (op == OP_ALLOC) begin
         if (size == '0) begin
            ans.status = STATUS_BAD_SIZE;
         end else if (freed_depth != 0) begin
            freed_depth = freed_depth - 1'b1;
            idx = freed_stack[freed_depth[IDX_W-1:0]];
            slot_live[idx] = 1'b1;
            slot_gen[idx] = slot_gen[idx] + 1'b1;
            if (slot_gen[idx] == '0) wrap_count++;
            ans.index = idx;
            ans.gen = slot_gen[idx];
         end else if (high_water < SLOT_COUNT) begin
            idx = high_water[IDX_W-1:0];
            high_water = high_water + 1'b1;
            slot_live[idx] = 1'b1;
            slot_gen[idx] = gen_type'(1);
            ans.index = idx;
            ans.gen = slot_gen[idx];
         end else begin
            ans.status = STATUS_FULL;
         end
      end else if (hidx >= high_water || !slot_live[hidx] || slot_gen[hidx] != hgen) begin
         ans.status = STATUS_IGNORED;
      end else begin
         slot_live[hidx] = 1'b0;
         if (freed_depth < SLOT_COUNT) begin
            freed_stack[freed_depth[IDX_W-1:0]] = hidx;
            freed_depth = freed_depth + 1'b1;
         end
      end
      status_seen[ans.status]++;
      awaited_answers = {awaited_answers, ans};
   endtask

   task automatic issue_request(input op_type op, input logic [SIZE_W-1:0] size,
                                input logic [HINDEX_W-1:0] hidx,
                                input logic [HGEN_W-1:0] hgen);
      int gap;
      gap = idle_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid             <= 1'b1;
      req_op                <= op;
      req_size_bytes        <= size;
      req_handle_index      <= hidx;
      req_handle_generation <= hgen;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      resolve_request(op, size, hidx, hgen);
   endtask

   task automatic issue_alloc(input logic [SIZE_W-1:0] size);
      issue_request(OP_ALLOC, size, 8'($urandom), 16'($urandom));
   endtask

   task automatic issue_release(input logic [HINDEX_W-1:0] hidx,
                                input logic [HGEN_W-1:0] hgen);
      issue_request(OP_RELEASE, $urandom, hidx, hgen);
   endtask

   task automatic test_directed_cases();
      issue_release(8'd0, 16'd0);
      issue_alloc(32'd0);
      issue_alloc(32'd1);
      issue_alloc(32'hFFFF_FFFF);
      issue_release(8'd1, 16'd2);
      issue_release(8'd200, 16'd1);
      issue_release(8'd255, 16'hFFFF);
      issue_release(8'd0, 16'd1);
      issue_release(8'd0, 16'd1);
      issue_release(8'd1, 16'd1);
      issue_alloc(32'h8000_0000);
      issue_alloc(32'h7FFF_FFFF);
      issue_alloc(32'h5555_5555);
      issue_release(8'd2, 16'd0);
      issue_release(8'd2, 16'd1);
      issue_alloc(32'd0);
      issue_alloc(32'hAAAA_AAAA);
      issue_release(8'd3, 16'd1);
   endtask

   task automatic test_random_traffic(input int item_total, input int alloc_pct);
      index_type idx;
      int        pick;
      for (int n = 0; n < item_total; n++) begin
         if (n % 100 == 0) pacing = ($urandom_range(0, 3) != 0);
         pick = $urandom_range(0, 99);
         if ($urandom_range(0, 99) < alloc_pct) begin
            issue_alloc(random_size());
         end else if (pick < 60 && find_slot(1'b1, idx)) begin
            issue_release(idx, slot_gen[idx]);
         end else if (pick < 70 && find_slot(1'b1, idx)) begin
            issue_release(idx, slot_gen[idx] + 16'($urandom_range(1, 65535)));
         end else if (pick < 80 && find_slot(1'b0, idx)) begin
            issue_release(idx, slot_gen[idx]);
         end else if (pick < 90 && high_water < SLOT_COUNT) begin
            issue_release(8'($urandom_range(int'(high_water), SLOT_COUNT - 1)),
                          16'($urandom_range(0, 2)));
         end else begin
            issue_release(8'($urandom), 16'($urandom));
         end
      end
   endtask

   task automatic test_table_full();
      index_type idx;
      pacing = 1'b1;
      while (high_water < SLOT_COUNT || freed_depth != 0) issue_alloc(32'($urandom) | 32'd1);
      issue_alloc(32'd9);
      issue_alloc(32'd0);
      idx = 8'($urandom);
      issue_release(idx, slot_gen[idx]);
      issue_alloc(32'd4096);
      issue_alloc(32'hFFFF_FFFF);
   endtask

   // Cycles one slot through release and reuse many times back to back, then
   // probes it with stale generations before releasing and reallocating it.
   task automatic test_slot_reuse();
      index_type idx;
      int        laps;
      pacing = 1'b0;
      idx = 8'($urandom);
      laps = 64;
      repeat (laps) begin
         issue_release(idx, slot_gen[idx]);
         issue_alloc(32'($urandom) | 32'd1);
      end
      issue_release(idx, 16'hFFFF);
      issue_release(idx, 16'd0);
      issue_release(idx, slot_gen[idx]);
      issue_alloc(32'd64);
   endtask

   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 99) < 25) stall_left <= idle_length();
      end
   end

   always @(posedge clock) begin : result_check
      answer_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_answers.size() == 0) begin
            $display("%0t: unexpected result transfer: status %0d index %0d generation %0d",
                     $time, rsp_status, rsp_slot_index, rsp_slot_generation);
            errors++;
         end else begin
            want = awaited_answers.pop_front();
            if (rsp_status !== want.status || rsp_slot_index !== want.index ||
                rsp_slot_generation !== want.gen) begin
               $display("%0t: expected status %0d index %0d generation %0d, got %0d %0d %0d",
                        $time, want.status, want.index, want.gen,
                        rsp_status, rsp_slot_index, rsp_slot_generation);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, awaited_answers.size());
         $display("generational_slot_allocator: mismatch");
         $finish;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_random_traffic(750, 55);
      test_table_full();
      test_slot_reuse();
      test_random_traffic(750, 50);
      req_valid <= 1'b0;
      while (awaited_answers.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("Checked %0d ok, %0d zero-size, %0d table-full and %0d ignored results.",
               status_seen[STATUS_OK], status_seen[STATUS_BAD_SIZE],
               status_seen[STATUS_FULL], status_seen[STATUS_IGNORED]);
      $display("Generations wrapped %0d times across %0d slots handed out.",
               wrap_count, high_water);
      if (errors == 0) begin
         $display("generational_slot_allocator: match");
      end else begin
         $display("generational_slot_allocator: mismatch");
      end
      $finish;
   end

endmodule
